// ===== design/assert_macros.svh =====
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_AFTER(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/tcs_pkg.sv =====
package tcs_pkg;

  localparam int COLUMNS_DEFAULT     = 80;
  localparam int ROWS_DEFAULT        = 25;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = 16;
  localparam int READ_ROW_W = 5;
  localparam int READ_COL_W = 7;
  localparam int CUR_ROW_W  = 5;
  localparam int CUR_COL_W  = 7;

  localparam logic [CHAR_W-1:0]  CH_CR            = 8'd13;
  localparam logic [CHAR_W-1:0]  CH_LF            = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_SPACE         = 8'h20;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;
  localparam logic [CELL_W-1:0]  RESET_CELL       = {TEXT_COLOR_RESET, CH_SPACE};

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Operation classes handed from the front to the back.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT,
    OP_CR,
    OP_LF,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SWEEP
  } back_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [CHAR_W-1:0]     char_code;
    logic [READ_ROW_W-1:0] read_row;
    logic [READ_COL_W-1:0] read_col;
  } req_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_value;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
  } rsp_t;

  typedef struct packed {
    op_t                   op;
    logic [CHAR_W-1:0]     char_code;
    logic [READ_ROW_W-1:0] read_row;
    logic [READ_COL_W-1:0] read_col;
  } entry_t;

endpackage

// ===== design/tcs_chan_if.sv =====
interface tcs_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/text_terminal_cursor_scroll_unit.sv =====
// Text terminal with a ROWS x COLUMNS screen store of 16-bit cells (character
// in the low byte, attribute in the high byte) and a cursor. Requests on req
// are put character (CR and LF handled as controls), read cell, and clear;
// each gives exactly one response on rsp carrying the cell (zero unless a
// valid read) and the cursor after the request. cfg writes the attribute
// used for new characters and blanking; it is always ready. A put, CR, LF
// or no-op is done when popped; a read then passes through a read state
// (registered read of the screen store). A line advance off the last row
// then sweeps one row of COLUMNS cells and a clear all ROWS*COLUMNS cells:
// both are bound by the single write port of the screen store, which blanks
// one cell per cycle. Scrolling moves no data; a rotating base row remaps the
// rows and only the row that becomes the bottom is blanked. After reset the
// store is swept to grey spaces, with req.ready held low. A queue of
// QUEUE_DEPTH entries decouples acceptance from execution, so requests keep
// being taken while a response waits or a clear or scroll sweep runs.
module text_terminal_cursor_scroll_unit import tcs_pkg::*; #(
  parameter int COLUMNS     = COLUMNS_DEFAULT,
  parameter int ROWS        = ROWS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  tcs_chan_if.sink   req,
  tcs_chan_if.source rsp,
  tcs_chan_if.sink   cfg
);
  // attribute register, written by a cfg transfer
  logic [COLOR_W-1:0] text_color;

  // front -> queue -> back
  logic   push, q_full, q_valid, pop, init_busy;
  entry_t push_entry, head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      text_color <= cfg.payload;
    end
  end

  // Front: takes a request transfer and classifies it (control character,
  // printable, read in or out of range, clear).
  tcs_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .req        (req),
    .init_busy  (init_busy),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Short queue between classification and execution.
  tcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_valid)
  );

  // Back: cursor, screen store, blanking sweeps and the response register.
  // It pops only when the response register is free, so responses leave in
  // request order.
  tcs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .init_busy  (init_busy),
    .rsp        (rsp)
  );
endmodule

// ===== design/tcs_queue.sv =====
module tcs_queue import tcs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   not_empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== design/tcs_front.sv =====
module tcs_front import tcs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  tcs_chan_if.sink req,
  input  logic     init_busy,
  input  logic     q_full,
  output logic     push,
  output entry_t   push_entry
);
  logic in_range;

  assign in_range  = (int'(req.payload.read_row) < ROWS) &&
                     (int'(req.payload.read_col) < COLUMNS);
  assign req.ready = !q_full && !init_busy;
  assign push      = req.valid && req.ready;

  always_comb begin
    push_entry.char_code = req.payload.char_code;
    push_entry.read_row  = req.payload.read_row;
    push_entry.read_col  = req.payload.read_col;
    unique case (req.payload.cmd)
      CMD_PUT: begin
        priority if (req.payload.char_code == CH_CR) begin
          push_entry.op = OP_CR;
        end else if (req.payload.char_code == CH_LF) begin
          push_entry.op = OP_LF;
        end else begin
          push_entry.op = OP_PUT;
        end
      end
      CMD_READ:  push_entry.op = in_range ? OP_READ : OP_NONE;
      CMD_CLEAR: push_entry.op = OP_CLEAR;
      default:   push_entry.op = OP_NONE;
    endcase
  end
endmodule

// ===== design/tcs_back.sv =====
module tcs_back import tcs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COLOR_W-1:0] text_color,
  input  logic               q_valid,
  input  entry_t             head,
  output logic               pop,
  output logic               init_busy,
  tcs_chan_if.source         rsp
);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PROW_W = ROW_W + 1;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS - 1);

  back_state_t       state, state_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [ROW_W-1:0]  base, base_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ADDR_W-1:0] sweep_addr, sweep_addr_next;
  logic [ADDR_W-1:0] sweep_last, sweep_last_next;
  logic [CELL_W-1:0] fill, fill_next;
  logic              init_pass, init_pass_next;
  logic              rsp_valid, rsp_valid_next;
  rsp_t              rsp_data, rsp_data_next;

  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic              out_free, col_last, row_last, newline, scroll;
  logic [ROW_W-1:0]  base_inc;
  logic [ADDR_W-1:0] cur_addr, top_row_addr;

  // Logical row -> physical row through the rotating base, then flat address.
  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic [ROW_W-1:0] r,
    input logic [COL_W-1:0] c,
    input logic [ROW_W-1:0] b
  );
    logic [PROW_W-1:0] p;
    p = {1'b0, r} + {1'b0, b};
    if (p >= PROW_W'(ROWS)) begin
      p = p - PROW_W'(ROWS);
    end
    return ADDR_W'(p * COLUMNS) + ADDR_W'(c);
  endfunction

  assign out_free     = !rsp_valid || rsp.ready;
  assign pop          = (state == BK_IDLE) && q_valid && out_free;
  assign col_last     = (cur_col == LAST_COL);
  assign row_last     = (cur_row == LAST_ROW);
  assign newline      = (head.op == OP_LF) || ((head.op == OP_PUT) && col_last);
  assign scroll       = newline && row_last;
  assign base_inc     = (base == LAST_ROW) ? '0 : base + 1'b1;
  assign cur_addr     = cell_addr(cur_row, cur_col, base);
  assign top_row_addr = ADDR_W'(base * COLUMNS);
  assign mem_raddr    = cell_addr(ROW_W'(head.read_row), COL_W'(head.read_col), base);
  assign init_busy    = init_pass;
  assign rsp.valid    = rsp_valid;
  assign rsp.payload  = rsp_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (pop) begin
          if (head.op == OP_READ) begin
            state_next = BK_READ;
          end else if ((head.op == OP_CLEAR) || scroll) begin
            state_next = BK_SWEEP;
          end
        end
      end
      BK_READ:  state_next = BK_IDLE;
      BK_SWEEP: begin
        if (sweep_addr == sweep_last) begin
          state_next = BK_IDLE;
        end
      end
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    base_next       = base;
    sweep_addr_next = sweep_addr;
    sweep_last_next = sweep_last;
    fill_next       = fill;
    init_pass_next  = init_pass;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_data_next   = rsp_data;
    mem_we          = 1'b0;
    mem_waddr       = cur_addr;
    mem_wdata       = {text_color, head.char_code};
    unique case (state)
      BK_IDLE: begin
        if (pop) begin
          if (head.op == OP_PUT) begin
            mem_we = 1'b1;
          end
          if (head.op == OP_CR) begin
            cur_col_next = '0;
          end
          if (newline) begin
            cur_col_next = '0;
            if (row_last) begin
              // new bottom row is the old top row, blanked by the sweep
              base_next       = base_inc;
              sweep_addr_next = top_row_addr;
              sweep_last_next = top_row_addr + ROW_SPAN;
              fill_next       = {text_color, CH_SPACE};
            end else begin
              cur_row_next = cur_row + 1'b1;
            end
          end else if (head.op == OP_PUT) begin
            cur_col_next = cur_col + 1'b1;
          end
          if (head.op == OP_CLEAR) begin
            cur_row_next    = '0;
            cur_col_next    = '0;
            base_next       = '0;
            sweep_addr_next = '0;
            sweep_last_next = LAST_ADDR;
            fill_next       = {text_color, CH_SPACE};
          end
          if (head.op != OP_READ) begin
            rsp_valid_next           = 1'b1;
            rsp_data_next.cell_value = '0;
            rsp_data_next.cursor_row = CUR_ROW_W'(cur_row_next);
            rsp_data_next.cursor_col = CUR_COL_W'(cur_col_next);
          end
        end
      end
      BK_READ: begin
        rsp_valid_next           = 1'b1;
        rsp_data_next.cell_value = mem_rdata;
        rsp_data_next.cursor_row = CUR_ROW_W'(cur_row);
        rsp_data_next.cursor_col = CUR_COL_W'(cur_col);
      end
      BK_SWEEP: begin
        mem_we          = 1'b1;
        mem_waddr       = sweep_addr;
        mem_wdata       = fill;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == sweep_last) begin
          init_pass_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_SWEEP;
      cur_row    <= '0;
      cur_col    <= '0;
      base       <= '0;
      sweep_addr <= '0;
      sweep_last <= LAST_ADDR;
      fill       <= RESET_CELL;
      init_pass  <= 1'b1;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      base       <= base_next;
      sweep_addr <= sweep_addr_next;
      sweep_last <= sweep_last_next;
      fill       <= fill_next;
      init_pass  <= init_pass_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp_data <= rsp_data_next;
  end
endmodule

// ===== design/tcs_checker.sv =====
`include "assert_macros.svh"

module tcs_checker import tcs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_payload
);
  // requests taken but not yet answered
  logic [7:0] outstanding;
  // reported cursor lies on the screen
  logic       cursor_ok;

  assign cursor_ok = (int'(rsp_payload.cursor_row) < ROWS) &&
                     (int'(rsp_payload.cursor_col) < COLUMNS);

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);
    end
  end

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
  `ASSERT_AFTER(a_init_blocks_req, clk, rst, !req_ready)
  `ASSERT_NOW(a_rsp_has_req, clk, rst, rsp_valid, outstanding != 8'd0)
  `ASSERT_NOW(a_cursor_range, clk, rst, rsp_valid, cursor_ok)
endmodule

bind text_terminal_cursor_scroll_unit tcs_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcs_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);
